FILE: src/bhpq_pkg.sv
// Shared types and codes for the binary heap priority queue.
`default_nettype none
package bhpq_pkg;
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // One memory access from the sift engine to the heap store.
  typedef struct packed {
    logic re;
    logic we;
  } mem_ctl_t;
endpackage
`default_nettype wire

FILE: src/bhpq_store.sv
// Heap entry memory: one synchronous port, registered read data.
`default_nettype none
module bhpq_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 48
) (
  input  wire logic             clk,
  input  wire bhpq_pkg::mem_ctl_t ctl,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [DW-1:0]    wdata,
  output logic      [DW-1:0]    rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

FILE: src/binary_heap_priority_queue.sv
// Binary heap priority queue: sift sequencer around one single-port entry memory.
// Push writes the entry at the end of the heap and, unless the heap was empty, sifts it
// up: read parent, compare, write parent down, per level. Pop reads root and last entry,
// then, if entries remain, sifts the last entry down: read left, read right, pick, write.
// Full and empty errors answer without a sift. Operations run one at a time, since every
// sift step goes through the single memory port; the held entry ends at its final slot.
// Reset: clears occupancy, sets min order, idles the sequencer; memory is not cleared.
`default_nettype none
module binary_heap_priority_queue #(
  parameter int CAPACITY     = 1024,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    func,
  input  wire logic [KEY_BITS-1:0]     key_in,
  input  wire logic [PAYLOAD_BITS-1:0] payload_in,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [KEY_BITS-1:0]          key_out,
  output logic [PAYLOAD_BITS-1:0]      payload_out,
  output logic                         entry_valid,
  output logic [1:0]                   status,
  output logic [$clog2(CAPACITY+1)-1:0] occupancy,
  output logic                         is_empty,
  output logic                         is_full
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = AW + 2;  // position arithmetic with room for 2p+2
  localparam int DW = KEY_BITS + PAYLOAD_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UP_RD = 4'd1;  // read parent
  localparam logic [3:0] S_UP_CK = 4'd2;  // compare with parent
  localparam logic [3:0] S_UP_WR = 4'd3;  // write parent into current slot
  localparam logic [3:0] S_P_RT  = 4'd4;  // read root
  localparam logic [3:0] S_P_LS  = 4'd5;  // read last
  localparam logic [3:0] S_P_LD  = 4'd6;  // latch last
  localparam logic [3:0] S_DN_L  = 4'd7;  // read left child
  localparam logic [3:0] S_DN_R  = 4'd8;  // latch left, read right
  localparam logic [3:0] S_DN_CK = 4'd9;  // pick best
  localparam logic [3:0] S_DN_WR = 4'd10; // write child into current slot
  localparam logic [3:0] S_FIN   = 4'd11; // write held entry at final slot
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]     state;
  logic           order_min;
  logic [CW-1:0]  count;
  logic [PW-1:0]  pos;
  logic [PW-1:0]  best;
  logic [DW-1:0]  hold;     // entry being sifted
  logic [DW-1:0]  lchild;
  logic [DW-1:0]  bestv;
  logic           has_r;

  bhpq_pkg::mem_ctl_t mctl;
  logic [AW-1:0]  maddr;
  logic [DW-1:0]  mwdata;
  logic [DW-1:0]  mrdata;

  bhpq_store #(.DEPTH(CAPACITY), .AW(AW), .DW(DW)) u_store (
    .clk(clk), .ctl(mctl), .addr(maddr), .wdata(mwdata), .rdata(mrdata)
  );

  function automatic logic beats(input logic omin, input logic [DW-1:0] a,
                                 input logic [DW-1:0] b);
    logic [KEY_BITS-1:0] ka;
    logic [KEY_BITS-1:0] kb;
    ka = a[DW-1 -: KEY_BITS];
    kb = b[DW-1 -: KEY_BITS];
    return omin ? (ka < kb) : (ka > kb);
  endfunction

  logic [PW-1:0] parent;
  logic [PW-1:0] lpos;
  logic [PW-1:0] cnt_w;
  assign parent = (pos - PW'(1)) >> 1;
  assign lpos   = {pos[PW-2:0], 1'b1};
  assign cnt_w  = PW'(count);

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    mctl   = '0;
    maddr  = pos[AW-1:0];
    mwdata = hold;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready && func == bhpq_pkg::FUNC_PUSH
            && count != CW'(CAPACITY)) begin
          mctl.we = 1'b1;
          maddr   = count[AW-1:0];
          mwdata  = {key_in, payload_in};
        end
      end
      S_UP_RD: begin mctl.re = 1'b1; maddr = parent[AW-1:0]; end
      S_UP_WR: begin mctl.we = 1'b1; mwdata = bestv; end
      S_P_RT:  begin mctl.re = 1'b1; maddr = '0; end
      S_P_LS:  begin mctl.re = 1'b1; maddr = count[AW-1:0]; end
      S_DN_L:  begin mctl.re = 1'b1; maddr = lpos[AW-1:0]; end
      S_DN_R:  begin mctl.re = 1'b1; maddr = AW'(lpos + PW'(1)); end
      S_DN_WR: begin mctl.we = 1'b1; mwdata = bestv; end
      S_FIN:   begin mctl.we = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      order_min <= 1'b1;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_min <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            key_out     <= '0;
            payload_out <= '0;
            entry_valid <= 1'b0;
            status      <= bhpq_pkg::STATUS_OK;
            if (func == bhpq_pkg::FUNC_PUSH) begin
              if (count == CW'(CAPACITY)) begin
                status <= bhpq_pkg::STATUS_FULL;
                state  <= S_OUT;
              end else begin
                hold  <= {key_in, payload_in};
                pos   <= PW'(count);
                count <= count + CW'(1);
                state <= (count == '0) ? S_OUT : S_UP_RD;
              end
            end else if (count == '0) begin
              status <= bhpq_pkg::STATUS_EMPTY;
              state  <= S_OUT;
            end else begin
              count <= count - CW'(1);
              pos   <= '0;
              state <= S_P_RT;
            end
          end
        end
        S_UP_RD: state <= S_UP_CK;
        S_UP_CK: begin
          if (beats(order_min, hold, mrdata)) begin
            bestv <= mrdata;
            state <= S_UP_WR;
          end else begin
            state <= S_FIN;
          end
        end
        S_UP_WR: begin
          pos   <= parent;
          state <= (parent == '0) ? S_FIN : S_UP_RD;
        end
        S_P_RT: state <= S_P_LS;
        S_P_LS: begin
          key_out     <= mrdata[DW-1 -: KEY_BITS];
          payload_out <= mrdata[PAYLOAD_BITS-1:0];
          entry_valid <= 1'b1;
          state       <= S_P_LD;
        end
        S_P_LD: begin
          hold  <= mrdata;
          state <= (count == '0) ? S_OUT : S_DN_L;
        end
        S_DN_L: begin
          if (lpos >= cnt_w) begin
            state <= S_FIN;
          end else begin
            has_r <= (lpos + PW'(1)) < cnt_w;
            state <= S_DN_R;
          end
        end
        S_DN_R: begin
          lchild <= mrdata;
          state  <= S_DN_CK;
        end
        S_DN_CK: begin
          // left first, then right against the current best; ties keep left
          if (has_r && beats(order_min, mrdata,
                             beats(order_min, lchild, hold) ? lchild : hold)) begin
            bestv <= mrdata;
            best  <= lpos + PW'(1);
            state <= S_DN_WR;
          end else if (beats(order_min, lchild, hold)) begin
            bestv <= lchild;
            best  <= lpos;
            state <= S_DN_WR;
          end else begin
            state <= S_FIN;
          end
        end
        S_DN_WR: begin
          pos   <= best;
          state <= S_DN_L;
        end
        S_FIN: state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign occupancy = count;
  assign is_empty  = (count == '0);
  assign is_full   = (count == CW'(CAPACITY));

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("occupancy beyond capacity");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while sifting");
  a_pop_valid_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_valid) |-> (status == bhpq_pkg::STATUS_OK))
    else $error("popped entry with error status");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(count)) else $error("occupancy moved mid-sift");
endmodule
`default_nettype wire
